/* hw/rtl/aup_pkg.sv */
package aup_pkg;

    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 32;
    localparam int RECIP_W  = 17;
    localparam int NUM_W    = 16;
    localparam int ALPHA_LO = 24;
    localparam int RED_LO   = 16;
    localparam int GREEN_LO = 8;
    localparam int BLUE_LO  = 0;
    localparam int RECIP_SHIFT = 16;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    typedef logic [RECIP_W-1:0] recip_t;
    typedef recip_t recip_tbl_t [256];

    // Enables of the four register stages of the pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

    // Builds floor(2^16 / a) for every alpha by restoring long division.
    // Entry zero is unused and holds zero.
    function automatic recip_tbl_t build_recip();
        recip_tbl_t tbl;
        logic [17:0] rem;
        logic [16:0] quo;
        logic [16:0] dividend;
        dividend = 17'h10000;
        tbl[0] = '0;
        for (int a = 1; a < 256; a++) begin
            rem = '0;
            quo = '0;
            for (int i = 16; i >= 0; i--) begin
                rem = {rem[16:0], dividend[i]};
                if (rem >= 18'(a)) begin
                    rem = rem - 18'(a);
                    quo[i] = 1'b1;
                end
            end
            tbl[a] = quo;
        end
        return tbl;
    endfunction

    localparam recip_tbl_t RECIP_TABLE = build_recip();

endpackage

/* hw/rtl/argb_unpremultiply.sv */
// Converts one premultiplied ARGB32 pixel per transaction into straight-alpha bytes: each
// colour channel becomes floor(channel * 255 / alpha), alpha passes through, a zero alpha
// leaves the colours untouched, and a colour above alpha saturates to 255 and sets clipped.
// The block is a four-stage pipeline that accepts a new pixel every clock while s_ready is high.
// The first stage loads at the edge that accepts the pixel; the pixel then passes through the
// second and third stages into the result register, the fourth stage, whose valid bit drives
// m_valid, and the result is taken from there with m_ready high. The division is done with a 256-entry
// reciprocal table, one multiplier per channel for the estimate and one for the
// back-multiply that corrects it, so the multipliers set the stage depth. Backpressure on
// m_ready stalls only the stages that are full, so bubbles are squeezed out and nothing is
// lost or repeated.
module argb_unpremultiply (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [aup_pkg::PIXEL_W-1:0]  s_premultiplied_pixel,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [aup_pkg::CHAN_W-1:0]   m_straight_red,
    output logic [aup_pkg::CHAN_W-1:0]   m_straight_green,
    output logic [aup_pkg::CHAN_W-1:0]   m_straight_blue,
    output logic [aup_pkg::CHAN_W-1:0]   m_alpha_out,
    output logic                         m_clipped
);

    localparam int CW = aup_pkg::CHAN_W;

    // Unpack the pixel word.
    logic [CW-1:0]   in_alpha, in_red, in_green, in_blue;
    aup_pkg::recip_t in_recip;

    assign in_alpha = s_premultiplied_pixel[aup_pkg::ALPHA_LO +: CW];
    assign in_red   = s_premultiplied_pixel[aup_pkg::RED_LO   +: CW];
    assign in_green = s_premultiplied_pixel[aup_pkg::GREEN_LO +: CW];
    assign in_blue  = s_premultiplied_pixel[aup_pkg::BLUE_LO  +: CW];

    // The reciprocal is looked up once and shared by all three channels.
    assign in_recip = aup_pkg::RECIP_TABLE[in_alpha];

    // Valid bits of the four stages; the last one is the output register.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    aup_pkg::pipe_en_t en;

    // A stage loads when it is empty or when its content moves on this cycle.
    assign en.s4 = !v4_reg || m_ready;
    assign en.s3 = !v3_reg || en.s4;
    assign en.s2 = !v2_reg || en.s3;
    assign en.s1 = !v1_reg || en.s2;

    assign s_ready = en.s1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en.s1) v1_reg <= s_valid;
            if (en.s2) v2_reg <= v1_reg;
            if (en.s3) v3_reg <= v2_reg;
            if (en.s4) v4_reg <= v3_reg;
        end
    end

    // Alpha travels alongside the channel pipelines.
    logic [CW-1:0] a1_reg, a2_reg, a3_reg, a4_reg;

    always_ff @(posedge aclk) begin
        if (en.s1) a1_reg <= in_alpha;
        if (en.s2) a2_reg <= a1_reg;
        if (en.s3) a3_reg <= a2_reg;
        if (en.s4) a4_reg <= a3_reg;
    end

    logic sat_red, sat_green, sat_blue;

    aup_chan_div u_red (
        .aclk   (aclk),
        .en     (en),
        .chan   (in_red),
        .alpha  (in_alpha),
        .recip  (in_recip),
        .result (m_straight_red),
        .sat    (sat_red)
    );

    aup_chan_div u_green (
        .aclk   (aclk),
        .en     (en),
        .chan   (in_green),
        .alpha  (in_alpha),
        .recip  (in_recip),
        .result (m_straight_green),
        .sat    (sat_green)
    );

    aup_chan_div u_blue (
        .aclk   (aclk),
        .en     (en),
        .chan   (in_blue),
        .alpha  (in_alpha),
        .recip  (in_recip),
        .result (m_straight_blue),
        .sat    (sat_blue)
    );

    assign m_valid     = v4_reg;
    assign m_alpha_out = a4_reg;
    assign m_clipped   = sat_red || sat_green || sat_blue;

endmodule

/* hw/rtl/aup_chan_div.sv */
module aup_chan_div (
    input  logic                        aclk,
    input  aup_pkg::pipe_en_t           en,
    input  logic [aup_pkg::CHAN_W-1:0]  chan,
    input  logic [aup_pkg::CHAN_W-1:0]  alpha,
    input  aup_pkg::recip_t             recip,
    output logic [aup_pkg::CHAN_W-1:0]  result,
    output logic                        sat
);

    localparam int CW = aup_pkg::CHAN_W;
    localparam int NW = aup_pkg::NUM_W;
    localparam int PW = aup_pkg::NUM_W + aup_pkg::RECIP_W;

    // Stage 1: operands, scaled numerator and per-channel special cases.
    logic [CW-1:0]   c1_reg, a1_reg;
    logic [NW-1:0]   n1_reg;
    aup_pkg::recip_t r1_reg;
    logic            zero1_reg, sat1_reg;

    // Stage 2: estimated quotient.
    logic [CW-1:0]   c2_reg, a2_reg, q2_reg;
    logic [NW-1:0]   n2_reg;
    logic            zero2_reg, sat2_reg;

    // Stage 3: back-multiplied estimate.
    logic [CW-1:0]   c3_reg, a3_reg, q3_reg;
    logic [NW-1:0]   n3_reg, prod3_reg;
    logic            zero3_reg, sat3_reg;

    // Stage 4: final byte.
    logic [CW-1:0]   res4_reg;
    logic            sat4_reg;

    logic [PW-1:0]   prod_full;
    logic [NW-1:0]   rem3;
    logic [CW-1:0]   q_fix;
    logic [CW-1:0]   res4_next;

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            c1_reg    <= chan;
            a1_reg    <= alpha;
            n1_reg    <= {chan, {CW{1'b0}}} - NW'(chan);
            r1_reg    <= recip;
            zero1_reg <= (alpha == '0);
            sat1_reg  <= (alpha != '0) && (chan > alpha);
        end
    end

    assign prod_full = PW'(n1_reg) * PW'(r1_reg);

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            c2_reg    <= c1_reg;
            a2_reg    <= a1_reg;
            n2_reg    <= n1_reg;
            q2_reg    <= prod_full[aup_pkg::RECIP_SHIFT +: CW];
            zero2_reg <= zero1_reg;
            sat2_reg  <= sat1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            c3_reg    <= c2_reg;
            a3_reg    <= a2_reg;
            n3_reg    <= n2_reg;
            q3_reg    <= q2_reg;
            prod3_reg <= NW'(q2_reg) * NW'(a2_reg);
            zero3_reg <= zero2_reg;
            sat3_reg  <= sat2_reg;
        end
    end

    // The estimate is at most one below the true quotient.
    assign rem3  = n3_reg - prod3_reg;
    assign q_fix = (rem3 >= NW'(a3_reg)) ? q3_reg + CW'(1) : q3_reg;

    always_comb begin
        if (zero3_reg) begin
            res4_next = c3_reg;
        end else if (sat3_reg) begin
            res4_next = aup_pkg::CHAN_MAX;
        end else begin
            res4_next = q_fix;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            res4_reg <= res4_next;
            sat4_reg <= sat3_reg;
        end
    end

    assign result = res4_reg;
    assign sat    = sat4_reg;

endmodule
